@@ hdl/ptfc_pkg.sv @@
// ============================================================================
// Prefix table flag classifier package
// Constants, request and response types and the case folding helper that the
// classifier modules share.
// ============================================================================
package ptfc_pkg;

	// Table geometry.
	localparam int TABLE_SLOTS = 16;
	localparam int NAME_BYTES  = 28;
	localparam int MEM_DEPTH   = TABLE_SLOTS * NAME_BYTES;

	// Field widths of the request, response and configuration channels.
	localparam int OPCODE_W     = 2;
	localparam int SLOT_FIELD_W = 4;
	localparam int POS_W        = 5;
	localparam int CHAR_W       = 8;
	localparam int PLEN_W       = 5;
	localparam int FLAG_W       = 8;
	localparam int CNT_W        = 5;
	localparam int MAP_W        = 16;
	localparam int REG_IDX_W    = 1;
	localparam int WDATA_W      = 8;

	// Internal widths derived from the table geometry.
	localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int LEN_W  = $clog2(NAME_BYTES + 1);
	localparam int ADDR_W = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

	// Request opcodes.
	localparam logic [OPCODE_W-1:0] OP_PAT  = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_SLOT = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_NAME = 2'd2;

	// Configuration register indexes.
	localparam logic [REG_IDX_W-1:0] REG_FLAG_MASK   = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT = 1'd1;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CHAR_W-1:0] data;
	} pat_wr_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] slot;
		logic [LEN_W-1:0]  len;
		logic [FLAG_W-1:0] bits;
	} slot_wr_t;

	typedef struct packed {
		logic [LEN_W-1:0]  len;
		logic [FLAG_W-1:0] bits;
	} slot_info_t;

	typedef struct packed {
		logic              start;
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic [FLAG_W-1:0] eflags;
	} name_cmd_t;

	typedef struct packed {
		logic [FLAG_W-1:0] flag_mask;
		logic [CNT_W-1:0]  entry_count;
	} cfg_regs_t;

	typedef struct packed {
		logic [FLAG_W-1:0] new_flags;
		logic [MAP_W-1:0]  matched_slots;
	} result_t;

	// Maps upper case ASCII letters onto lower case; other bytes pass.
	function automatic logic [CHAR_W-1:0] fold_case(input logic [CHAR_W-1:0] c);
		logic [CHAR_W-1:0] r;
		r = c;
		if (c inside {[8'h41:8'h5A]}) begin
			r = c + 8'h20;
		end
		return r;
	endfunction

endpackage

@@ hdl/ptfc_req_if.sv @@
// ============================================================================
// Classifier request channel
// Valid/ready channel carrying one table write or one entry name byte.
// ============================================================================
interface ptfc_req_if;
	logic                               valid;
	logic                               ready;
	logic [ptfc_pkg::OPCODE_W-1:0]      opcode;
	logic [ptfc_pkg::SLOT_FIELD_W-1:0]  slot;
	logic [ptfc_pkg::POS_W-1:0]         position;
	logic [ptfc_pkg::CHAR_W-1:0]        char_byte;
	logic [ptfc_pkg::PLEN_W-1:0]        pattern_len;
	logic [ptfc_pkg::FLAG_W-1:0]        record_bits;
	logic [ptfc_pkg::FLAG_W-1:0]        entry_flags;
	logic                               last;

	modport source (
		output valid, opcode, slot, position, char_byte, pattern_len,
		record_bits, entry_flags, last,
		input  ready
	);
	modport sink (
		input  valid, opcode, slot, position, char_byte, pattern_len,
		record_bits, entry_flags, last,
		output ready
	);
endinterface

@@ hdl/ptfc_rsp_if.sv @@
// ============================================================================
// Classifier response channel
// Valid/ready channel carrying the updated flags and the matched slot map.
// ============================================================================
interface ptfc_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [ptfc_pkg::FLAG_W-1:0]   new_flags;
	logic [ptfc_pkg::MAP_W-1:0]    matched_slots;

	modport source (output valid, new_flags, matched_slots, input ready);
	modport sink   (input valid, new_flags, matched_slots, output ready);
endinterface

@@ hdl/ptfc_cfg_if.sv @@
// ============================================================================
// Classifier configuration channel
// Valid/ready register write channel with a register index and write data.
// ============================================================================
interface ptfc_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [ptfc_pkg::REG_IDX_W-1:0]  reg_index;
	logic [ptfc_pkg::WDATA_W-1:0]    wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink   (input valid, reg_index, wdata, output ready);
endinterface

@@ hdl/ptfc_slot_table.sv @@
// ============================================================================
// Classifier slot table
// Per slot pattern length and flag bits, written by slot requests and read
// at the slot that the match engine is currently evaluating.
// ============================================================================
module ptfc_slot_table (
	input  logic                               clk,
	input  ptfc_pkg::slot_wr_t                 slot_wr,
	input  logic [ptfc_pkg::SLOT_W-1:0]        rd_slot,
	output ptfc_pkg::slot_info_t               slot_info
);

	logic [ptfc_pkg::LEN_W-1:0]  len_q  [ptfc_pkg::TABLE_SLOTS];
	logic [ptfc_pkg::FLAG_W-1:0] bits_q [ptfc_pkg::TABLE_SLOTS];

	// Contents are undefined until written, so no reset.
	always_ff @(posedge clk) begin
		if (slot_wr.en) begin
			len_q[slot_wr.slot]  <= slot_wr.len;
			bits_q[slot_wr.slot] <= slot_wr.bits;
		end
	end

	assign slot_info.len  = len_q[rd_slot];
	assign slot_info.bits = bits_q[rd_slot];

endmodule

@@ hdl/ptfc_match_engine.sv @@
// ============================================================================
// Classifier match engine
// Holds the pattern memory and sweeps all slots for every name byte, keeping
// per slot mismatch bits and building the result on the last byte.
// ============================================================================
module ptfc_match_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ptfc_pkg::pat_wr_t                  pat_wr,
	input  ptfc_pkg::name_cmd_t                name_cmd,
	input  ptfc_pkg::cfg_regs_t                cfg_regs,
	input  ptfc_pkg::slot_info_t               slot_info,
	input  logic                               out_free,
	output logic [ptfc_pkg::SLOT_W-1:0]        rd_slot,
	output logic                               idle,
	output logic                               res_valid,
	output ptfc_pkg::result_t                  result
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SWEEP = 2'd1;
	localparam logic [1:0] ST_TAIL  = 2'd2;
	localparam logic [1:0] ST_DRAIN = 2'd3;

	logic [1:0]                        state_q;
	logic [ptfc_pkg::SLOT_W-1:0]       iss_q;
	logic [ptfc_pkg::ADDR_W-1:0]       base_q;
	logic [ptfc_pkg::LEN_W-1:0]        cmp_pos_q;
	logic                              cmp_en_q;
	logic [ptfc_pkg::LEN_W-1:0]        bs_q;
	logic [ptfc_pkg::CHAR_W-1:0]       ch_q;
	logic                              last_q;
	logic [ptfc_pkg::FLAG_W-1:0]       flags_q;
	logic [ptfc_pkg::MAP_W-1:0]        map_q;
	logic [ptfc_pkg::TABLE_SLOTS-1:0]  mm_q;
	logic                              vld_s1;
	logic [ptfc_pkg::SLOT_W-1:0]       slot_s1;
	logic [ptfc_pkg::CHAR_W-1:0]       rdata_s1;

	logic [ptfc_pkg::CHAR_W-1:0]       mem [ptfc_pkg::MEM_DEPTH];

	logic                              rd_en;
	logic [ptfc_pkg::ADDR_W-1:0]       rd_addr;
	logic [ptfc_pkg::CHAR_W-1:0]       pat_byte;
	logic                              new_mis;
	logic                              mm_fin;
	logic                              in_use;
	logic                              hit;

	// The pattern memory is only read while the name is still within reach.
	assign rd_en   = (state_q == ST_SWEEP) && cmp_en_q;
	assign rd_addr = ptfc_pkg::ADDR_W'(base_q + ptfc_pkg::ADDR_W'(cmp_pos_q));

	always_ff @(posedge clk) begin
		if (pat_wr.en) begin
			mem[pat_wr.addr] <= pat_wr.data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	assign pat_byte = ptfc_pkg::fold_case(rdata_s1);
	assign new_mis  = cmp_en_q && (cmp_pos_q < slot_info.len) && (pat_byte != ch_q);
	assign mm_fin   = mm_q[slot_s1] | new_mis;
	assign in_use   = 32'(slot_s1) < 32'(cfg_regs.entry_count);
	assign hit      = !mm_fin && (slot_info.len <= bs_q) && in_use;
	assign rd_slot  = slot_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			iss_q     <= '0;
			base_q    <= '0;
			cmp_pos_q <= '0;
			cmp_en_q  <= 1'b0;
			bs_q      <= '0;
			ch_q      <= '0;
			last_q    <= 1'b0;
			flags_q   <= '0;
			map_q     <= '0;
			mm_q      <= '0;
			vld_s1    <= 1'b0;
			slot_s1   <= '0;
		end else begin
			vld_s1  <= (state_q == ST_SWEEP);
			slot_s1 <= iss_q;
			case (state_q)
				ST_IDLE: begin
					if (name_cmd.start) begin
						cmp_pos_q <= bs_q;
						cmp_en_q  <= 32'(bs_q) < ptfc_pkg::NAME_BYTES;
						if (32'(bs_q) < ptfc_pkg::NAME_BYTES) begin
							bs_q <= bs_q + ptfc_pkg::LEN_W'(1);
						end
						ch_q    <= name_cmd.ch;
						last_q  <= name_cmd.last;
						flags_q <= name_cmd.eflags & ~cfg_regs.flag_mask;
						map_q   <= '0;
						iss_q   <= '0;
						base_q  <= '0;
						state_q <= ST_SWEEP;
					end
				end
				ST_SWEEP: begin
					iss_q  <= iss_q + ptfc_pkg::SLOT_W'(1);
					base_q <= ptfc_pkg::ADDR_W'(base_q + ptfc_pkg::ADDR_W'(ptfc_pkg::NAME_BYTES));
					if (iss_q == ptfc_pkg::SLOT_W'(ptfc_pkg::TABLE_SLOTS - 1)) begin
						state_q <= ST_TAIL;
					end
				end
				ST_TAIL: begin
					state_q <= last_q ? ST_DRAIN : ST_IDLE;
				end
				ST_DRAIN: begin
					if (out_free) begin
						mm_q    <= '0;
						bs_q    <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Second stage: the pattern byte of slot_s1 is back from memory.
			if (vld_s1) begin
				mm_q[slot_s1] <= mm_fin;
				if (last_q && hit) begin
					flags_q <= flags_q | slot_info.bits;
					if (32'(slot_s1) < ptfc_pkg::MAP_W) begin
						map_q <= map_q | (ptfc_pkg::MAP_W'(1) << slot_s1);
					end
				end
			end
		end
	end

	assign idle                 = (state_q == ST_IDLE);
	assign res_valid            = (state_q == ST_DRAIN) && out_free;
	assign result.new_flags     = flags_q;
	assign result.matched_slots = map_q;

endmodule

@@ hdl/prefix_table_flag_classifier_core.sv @@
// ============================================================================
// Prefix table flag classifier
// Matches streamed entry names against a table of case-insensitive prefix
// patterns and returns updated flags plus a map of the matching slots.
// ============================================================================
// A table write request does not hold the block, and the next request
// is taken in the cycle after it. A name byte request holds the block through
// its accept in the idle state, a sweep state with one pattern memory read per
// slot, and a tail state to finish the last compare. A last name byte adds a
// drain state that waits for the response register to be free and hands the
// result over, and the next request waits for that handover.
// Reset clears the state machine, the mismatch bits, the byte count, both
// configuration registers and the response valid; tables are not cleared.
module prefix_table_flag_classifier_core (
	input  logic       clk,
	input  logic       arst_n,
	ptfc_req_if.sink   req,
	ptfc_rsp_if.source rsp,
	ptfc_cfg_if.sink   cfg
);

	// Configuration registers. The user must write them only while the block is
	// idle; the block itself does not enforce this, and the port is always ready.
	ptfc_pkg::cfg_regs_t  cfg_q;

	ptfc_pkg::pat_wr_t    pat_wr;
	ptfc_pkg::slot_wr_t   slot_wr;
	ptfc_pkg::name_cmd_t  name_cmd;
	ptfc_pkg::slot_info_t slot_info;
	ptfc_pkg::result_t    eng_result;
	ptfc_pkg::result_t    out_q;

	logic [ptfc_pkg::SLOT_W-1:0] rd_slot;
	logic                        eng_idle;
	logic                        res_valid;
	logic                        out_valid_q;
	logic                        out_free;
	logic                        accept;
	logic                        slot_ok;
	logic                        pos_ok;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg.valid) begin
			case (cfg.reg_index)
				ptfc_pkg::REG_FLAG_MASK: begin
					cfg_q.flag_mask <= cfg.wdata[ptfc_pkg::FLAG_W-1:0];
				end
				ptfc_pkg::REG_ENTRY_COUNT: begin
					cfg_q.entry_count <= cfg.wdata[ptfc_pkg::CNT_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	// The block takes a new request whenever the match engine is idle. A
	// result waiting in the response register does not hold off requests;
	// the engine itself waits for the register only when it has a result.
	assign req.ready = eng_idle;
	assign accept    = req.valid && req.ready;

	// Writes to slots or positions outside the table are dropped.
	assign slot_ok = 32'(req.slot) < ptfc_pkg::TABLE_SLOTS;
	assign pos_ok  = 32'(req.position) < ptfc_pkg::NAME_BYTES;

	// Pattern bytes live at slot * NAME_BYTES + position.
	assign pat_wr.en   = accept && (req.opcode == ptfc_pkg::OP_PAT) && slot_ok && pos_ok;
	assign pat_wr.addr = ptfc_pkg::ADDR_W'(32'(req.slot) * ptfc_pkg::NAME_BYTES
		+ 32'(req.position));
	assign pat_wr.data = req.char_byte;

	// Pattern lengths beyond the name buffer are saturated on the way in.
	assign slot_wr.en   = accept && (req.opcode == ptfc_pkg::OP_SLOT) && slot_ok;
	assign slot_wr.slot = ptfc_pkg::SLOT_W'(req.slot);
	assign slot_wr.len  = (32'(req.pattern_len) > ptfc_pkg::NAME_BYTES)
		? ptfc_pkg::LEN_W'(ptfc_pkg::NAME_BYTES) : ptfc_pkg::LEN_W'(req.pattern_len);
	assign slot_wr.bits = req.record_bits;

	// Name bytes are folded to lower case once, before the slot sweep.
	// Opcode 3 falls through all three decodes and is simply consumed.
	assign name_cmd.start  = accept && (req.opcode == ptfc_pkg::OP_NAME);
	assign name_cmd.ch     = ptfc_pkg::fold_case(req.char_byte);
	assign name_cmd.last   = req.last;
	assign name_cmd.eflags = req.entry_flags;

	ptfc_slot_table u_slot_table (
		.clk       (clk),
		.slot_wr   (slot_wr),
		.rd_slot   (rd_slot),
		.slot_info (slot_info)
	);

	ptfc_match_engine u_match_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.pat_wr    (pat_wr),
		.name_cmd  (name_cmd),
		.cfg_regs  (cfg_q),
		.slot_info (slot_info),
		.out_free  (out_free),
		.rd_slot   (rd_slot),
		.idle      (eng_idle),
		.res_valid (res_valid),
		.result    (eng_result)
	);

	// Response register: it is free when empty or when its result leaves in
	// this cycle, so back-to-back results need no bubble.
	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= eng_result;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.new_flags     = out_q.new_flags;
	assign rsp.matched_slots = out_q.matched_slots;

endmodule

@@ hdl/ptfc_checker.sv @@
// ============================================================================
// Classifier port checker
// Checks request and response behavior seen at the classifier's ports.
// ============================================================================
module ptfc_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              req_valid,
	input logic                              req_ready,
	input logic [ptfc_pkg::OPCODE_W-1:0]     req_opcode,
	input logic                              rsp_valid,
	input logic                              rsp_ready,
	input logic [ptfc_pkg::FLAG_W-1:0]       rsp_new_flags,
	input logic [ptfc_pkg::MAP_W-1:0]        rsp_matched_slots
);

	// An edge taken under reset clears the response valid, and no new
	// response can be built in the cycle that follows it.
	a_no_rsp_in_reset: assert property (@(posedge clk)
		!arst_n |=> !rsp_valid)
		else $error("response valid during reset");

	// A name byte starts a slot sweep, so the next request must wait.
	a_name_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_opcode == ptfc_pkg::OP_NAME |=> !req_ready)
		else $error("request taken during slot sweep");

	// A table write does not hold the request channel.
	a_write_single: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready
		&& (req_opcode == ptfc_pkg::OP_PAT || req_opcode == ptfc_pkg::OP_SLOT)
		|=> req_ready)
		else $error("table write held the request channel");

	// A new response only appears out of a sweep, never while idle.
	a_rsp_from_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> !$past(req_ready))
		else $error("response without a finished sweep");

	// A stalled response holds its contents.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_flags)
		&& $stable(rsp_matched_slots))
		else $error("stalled response changed");

endmodule

bind prefix_table_flag_classifier_core ptfc_checker u_ptfc_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.req_opcode        (req.opcode),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_new_flags     (rsp.new_flags),
	.rsp_matched_slots (rsp.matched_slots)
);
